>>> hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define SECE_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication
`define SECE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> hdl/sece_pkg.sv
// ----------------------------------------------------------------------------
// sece_pkg
// Types and constants of the SPI Ethernet command engine.
// ----------------------------------------------------------------------------
package sece_pkg;

    typedef enum logic [2:0] {
        K_RCR = 3'd0,
        K_WCR = 3'd1,
        K_BFS = 3'd2,
        K_BFC = 3'd3,
        K_RBM = 3'd4,
        K_WBM = 3'd5,
        K_SRC = 3'd6,
        K_NOP = 3'd7
    } kind_t;

    typedef enum logic [2:0] {
        S_CLEAR = 3'b001,
        S_FETCH = 3'b010,
        S_EXEC  = 3'b100
    } state_t;

    typedef struct packed {
        logic       first;
        kind_t      kind;
        logic [4:0] addr;
        logic [7:0] data;
    } item_t;

    typedef struct packed {
        logic [7:0]  miso;
        logic        go;
        logic [12:0] first_addr;
        logic [12:0] last_addr;
        logic        empty;
        logic        pad;
    } result_t;

    // Command bytes and opcode fields
    localparam logic [7:0] CMD_SRC = 8'hFF;
    localparam logic [7:0] CMD_RBM = 8'h3A;
    localparam logic [7:0] CMD_WBM = 8'h7A;
    localparam logic [2:0] OP_RCR  = 3'b000;
    localparam logic [2:0] OP_WCR  = 3'b010;
    localparam logic [2:0] OP_BFS  = 3'b100;
    localparam logic [2:0] OP_BFC  = 3'b101;

    // Register map
    localparam logic [4:0] BANK_SIZE  = 5'h1B;
    localparam logic [4:0] A_ECON1    = 5'h1F;
    localparam logic [4:0] A_ECON2    = 5'h1E;
    localparam logic [4:0] A_ERXFCON  = 5'h18;
    localparam logic [4:0] A_EPKTCNT  = 5'h19;
    localparam logic [4:0] A_MACON3   = 5'h02;
    localparam logic [4:0] A_ERXSTL   = 5'h08;
    localparam logic [4:0] A_ERXSTH   = 5'h09;
    localparam logic [4:0] A_DMY_LAST = 5'h05;
    localparam logic [4:0] A_DMY_ALT  = 5'h0A;

    localparam int C_EIR   = 1;
    localparam int C_ESTAT = 2;
    localparam int C_ECON2 = 3;
    localparam int C_ECON1 = 4;

    localparam int P_ERDPT  = 0;
    localparam int P_EWRPT  = 2;
    localparam int P_ETXST  = 4;
    localparam int P_ETXND  = 6;
    localparam int P_ERXST  = 8;
    localparam int P_ERXND  = 10;
    localparam int P_ERWRPT = 14;

    // Reset values and bit masks
    localparam logic [7:0] ERXFCON_RST   = 8'hA1;
    localparam logic [7:0] ECON2_RST     = 8'h80;
    localparam logic [7:0] ESTAT_RST     = 8'h01;
    localparam logic [7:0] TX_REQ_BIT    = 8'h08;
    localparam logic [7:0] TX_DONE_FLAG  = 8'h08;
    localparam logic [7:0] ECON2_PKDEC   = 8'h40;
    localparam logic [7:0] PKT_PEND_FLAG = 8'h40;
    localparam logic [7:0] MACON3_PAD    = 8'hE0;

endpackage

>>> hdl/sece_ram.sv
// ----------------------------------------------------------------------------
// sece_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sece_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> hdl/sece_fifo.sv
// ----------------------------------------------------------------------------
// sece_fifo
// Small register queue; DEPTH is a power of two.
// ----------------------------------------------------------------------------
module sece_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] dout,
    output logic             empty
);

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] data_reg [DEPTH];
    logic [IW-1:0]    wr_reg, wr_next;
    logic [IW-1:0]    rd_reg, rd_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign full    = (cnt_reg == CW'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = data_reg[rd_reg];

    always_comb
    begin
        wr_next  = do_push ? IW'(wr_reg + 1'b1) : wr_reg;
        rd_next  = do_pop ? IW'(rd_reg + 1'b1) : rd_reg;
        cnt_next = CW'(cnt_reg + CW'(do_push) - CW'(do_pop));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            data_reg[wr_reg] <= din;
        end
    end

endmodule

>>> hdl/sece_front.sv
// ----------------------------------------------------------------------------
// sece_front
// Accepts SPI bytes, tracks the active command and target register and
// tags each byte with its command class.
// ----------------------------------------------------------------------------
module sece_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic [7:0]           mosi_byte,
    input  logic                 first_byte,
    input  logic                 busy,
    input  logic                 q_full,
    output logic                 q_push,
    output sece_pkg::item_t      q_item
);

    sece_pkg::kind_t cmd_reg, cmd_next;
    logic [4:0]      tgt_reg, tgt_next;
    sece_pkg::kind_t dec_kind;
    logic            dec_tgt;

    assign full   = q_full || busy;
    assign q_push = push && !full;

    // Decode the command byte
    always_comb
    begin
        dec_tgt  = 1'b0;
        dec_kind = sece_pkg::K_NOP;
        priority if (mosi_byte == sece_pkg::CMD_SRC)
        begin
            dec_kind = sece_pkg::K_SRC;
        end
        else if (mosi_byte == sece_pkg::CMD_RBM)
        begin
            dec_kind = sece_pkg::K_RBM;
        end
        else if (mosi_byte == sece_pkg::CMD_WBM)
        begin
            dec_kind = sece_pkg::K_WBM;
        end
        else
        begin
            dec_tgt = 1'b1;
            unique case (mosi_byte[7:5])
                sece_pkg::OP_RCR: dec_kind = sece_pkg::K_RCR;
                sece_pkg::OP_WCR: dec_kind = sece_pkg::K_WCR;
                sece_pkg::OP_BFS: dec_kind = sece_pkg::K_BFS;
                sece_pkg::OP_BFC: dec_kind = sece_pkg::K_BFC;
                default:          dec_kind = sece_pkg::K_NOP;
            endcase
        end
    end

    always_comb
    begin
        cmd_next = cmd_reg;
        tgt_next = tgt_reg;
        if (q_push && first_byte)
        begin
            cmd_next = dec_kind;
            if (dec_tgt)
            begin
                tgt_next = mosi_byte[4:0];
            end
        end
        q_item.first = first_byte;
        q_item.kind  = first_byte ? dec_kind : cmd_reg;
        q_item.addr  = tgt_next;
        q_item.data  = mosi_byte;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_reg <= sece_pkg::K_RCR;
            tgt_reg <= '0;
        end
        else
        begin
            cmd_reg <= cmd_next;
            tgt_reg <= tgt_next;
        end
    end

endmodule

>>> hdl/sece_back.sv
// ----------------------------------------------------------------------------
// sece_back
// Executes classified bytes: register file, bank select, buffer memory
// streams and write side effects. Clears the buffer memory after reset.
// ----------------------------------------------------------------------------
module sece_back #(
    parameter int BUFFER_BYTES = 8192
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_empty,
    input  sece_pkg::item_t      q_item,
    output logic                 q_pop,
    input  logic                 out_full,
    output logic                 out_push,
    output sece_pkg::result_t    out_res,
    output logic                 busy
);

    localparam int PW = $clog2(BUFFER_BYTES);

    sece_pkg::state_t  state_reg, state_next;
    logic [PW-1:0]     clr_reg, clr_next;
    sece_pkg::item_t   it_reg;
    logic [1:0]        bank_reg;
    logic [PW-1:0]     rdp_reg;

    logic [7:0]   bk0_reg [16];
    logic [7:0]   bk0_next [16];
    logic [7:0]   com_reg [5];
    logic [7:0]   com_next [5];
    logic [7:0]   erxf_reg, erxf_next;
    logic [7:0]   epkt_reg, epkt_next;
    logic [7:0]   mac3_reg, mac3_next;
    logic [127:0] vld_reg, vld_next;
    logic         dmy_reg, dmy_next;
    logic [7:0]   held_reg, held_next;

    logic [PW-1:0] cur_rd, rx_nd, rx_st, rdp_calc, cur_wr;
    logic          fetch, commit;
    logic [7:0]    pkt_q, rram_q, r_val, w_val;
    logic [6:0]    ridx;
    logic [4:0]    cofs;
    logic          is_com, is_ram;
    logic          pkt_we, rram_we;
    logic [PW-1:0] pkt_waddr, pkt_raddr;
    logic [7:0]    pkt_wdata;
    logic [PW-1:0] st, nd;
    logic [15:0]   st1_16, nd_16, rx_16, wr_16, rd_16;

    function automatic logic [PW-1:0] pair(input logic [7:0] lo, input logic [7:0] hi);
        logic [15:0] v;
        v = {hi, lo};
        return v[PW-1:0];
    endfunction

    assign busy   = (state_reg == sece_pkg::S_CLEAR);
    assign fetch  = (state_reg == sece_pkg::S_FETCH) && !q_empty;
    assign commit = (state_reg == sece_pkg::S_EXEC) && !out_full;
    assign q_pop  = fetch;

    // Next buffer read address, wrapping at the receive end
    assign cur_rd    = pair(bk0_reg[sece_pkg::P_ERDPT], bk0_reg[sece_pkg::P_ERDPT + 1]);
    assign rx_nd     = pair(bk0_reg[sece_pkg::P_ERXND], bk0_reg[sece_pkg::P_ERXND + 1]);
    assign rx_st     = pair(bk0_reg[sece_pkg::P_ERXST], bk0_reg[sece_pkg::P_ERXST + 1]);
    assign cur_wr    = pair(bk0_reg[sece_pkg::P_EWRPT], bk0_reg[sece_pkg::P_EWRPT + 1]);
    assign rdp_calc  = (cur_rd == rx_nd) ? rx_st : PW'(cur_rd + 1'b1);
    assign pkt_raddr = q_item.first ? cur_rd : rdp_calc;

    assign pkt_we    = busy || (commit && !it_reg.first && it_reg.kind == sece_pkg::K_WBM);
    assign pkt_waddr = busy ? clr_reg : cur_wr;
    assign pkt_wdata = busy ? 8'h00 : it_reg.data;

    sece_ram #(
        .WIDTH (8),
        .DEPTH (BUFFER_BYTES)
    ) u_pkt_ram (
        .clk   (clk),
        .we    (pkt_we),
        .waddr (pkt_waddr),
        .wdata (pkt_wdata),
        .re    (fetch),
        .raddr (pkt_raddr),
        .rdata (pkt_q)
    );

    assign ridx = {bank_reg, it_reg.addr};

    sece_ram #(
        .WIDTH (8),
        .DEPTH (128)
    ) u_reg_ram (
        .clk   (clk),
        .we    (rram_we),
        .waddr (ridx),
        .wdata (w_val),
        .re    (fetch),
        .raddr ({com_reg[sece_pkg::C_ECON1][1:0], q_item.addr}),
        .rdata (rram_q)
    );

    // Current value of the target register
    always_comb
    begin
        is_com = (it_reg.addr >= sece_pkg::BANK_SIZE);
        cofs   = it_reg.addr - sece_pkg::BANK_SIZE;
        is_ram = 1'b0;
        priority if (is_com)
        begin
            r_val = com_reg[cofs[2:0]];
        end
        else if (bank_reg == 2'd0 && !it_reg.addr[4])
        begin
            r_val = bk0_reg[it_reg.addr[3:0]];
        end
        else if (bank_reg == 2'd1 && it_reg.addr == sece_pkg::A_ERXFCON)
        begin
            r_val = erxf_reg;
        end
        else if (bank_reg == 2'd1 && it_reg.addr == sece_pkg::A_EPKTCNT)
        begin
            r_val = epkt_reg;
        end
        else if (bank_reg == 2'd2 && it_reg.addr == sece_pkg::A_MACON3)
        begin
            r_val = mac3_reg;
        end
        else
        begin
            is_ram = 1'b1;
            r_val  = vld_reg[ridx] ? rram_q : 8'h00;
        end

        unique case (it_reg.kind)
            sece_pkg::K_BFS: w_val = r_val | it_reg.data;
            sece_pkg::K_BFC: w_val = r_val & ~it_reg.data;
            default:         w_val = it_reg.data;
        endcase
    end

    assign rram_we = commit && !it_reg.first && is_ram &&
                     (it_reg.kind == sece_pkg::K_WCR || it_reg.kind == sece_pkg::K_BFS ||
                      it_reg.kind == sece_pkg::K_BFC);

    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        bk0_next   = bk0_reg;
        com_next   = com_reg;
        erxf_next  = erxf_reg;
        epkt_next  = epkt_reg;
        mac3_next  = mac3_reg;
        vld_next   = vld_reg;
        dmy_next   = dmy_reg;
        held_next  = held_reg;
        out_res    = '0;
        st         = '0;
        nd         = '0;
        st1_16     = '0;
        nd_16      = '0;
        rx_16      = '0;
        wr_16      = '0;
        rd_16      = '0;

        unique case (state_reg)
            sece_pkg::S_CLEAR:
            begin
                clr_next = PW'(clr_reg + 1'b1);
                if (clr_reg == PW'(BUFFER_BYTES - 1))
                begin
                    state_next = sece_pkg::S_FETCH;
                end
            end
            sece_pkg::S_FETCH:
            begin
                if (fetch)
                begin
                    state_next = sece_pkg::S_EXEC;
                end
            end
            sece_pkg::S_EXEC:
            begin
                if (commit)
                begin
                    state_next = sece_pkg::S_FETCH;
                    if (it_reg.first)
                    begin
                        dmy_next = 1'b0;
                        unique case (it_reg.kind)
                            sece_pkg::K_SRC:
                            begin
                                for (int i = 0; i < 16; i++)
                                begin
                                    bk0_next[i] = 8'h00;
                                end
                                for (int i = 0; i < 5; i++)
                                begin
                                    com_next[i] = 8'h00;
                                end
                                com_next[sece_pkg::C_ECON2] = sece_pkg::ECON2_RST;
                                com_next[sece_pkg::C_ESTAT] = sece_pkg::ESTAT_RST;
                                erxf_next = sece_pkg::ERXFCON_RST;
                                epkt_next = 8'h00;
                                mac3_next = 8'h00;
                                vld_next  = '0;
                                held_next = 8'h00;
                            end
                            sece_pkg::K_RBM:
                            begin
                                held_next = pkt_q;
                            end
                            sece_pkg::K_RCR:
                            begin
                                // Bank 2 and part of bank 3 answer one beat late
                                dmy_next = (bank_reg == 2'd2) ||
                                           (bank_reg == 2'd3 &&
                                            (it_reg.addr <= sece_pkg::A_DMY_LAST ||
                                             it_reg.addr == sece_pkg::A_DMY_ALT));
                                held_next = dmy_next ? 8'h00 : r_val;
                            end
                            default:
                            begin
                                held_next = 8'h00;
                            end
                        endcase
                    end
                    else
                    begin
                        unique case (it_reg.kind)
                            sece_pkg::K_WCR, sece_pkg::K_BFS, sece_pkg::K_BFC:
                            begin
                                priority if (is_com)
                                begin
                                    com_next[cofs[2:0]] = w_val;
                                end
                                else if (bank_reg == 2'd0 && !it_reg.addr[4])
                                begin
                                    bk0_next[it_reg.addr[3:0]] = w_val;
                                end
                                else if (bank_reg == 2'd1 && it_reg.addr == sece_pkg::A_ERXFCON)
                                begin
                                    erxf_next = w_val;
                                end
                                else if (bank_reg == 2'd1 && it_reg.addr == sece_pkg::A_EPKTCNT)
                                begin
                                    epkt_next = w_val;
                                end
                                else if (bank_reg == 2'd2 && it_reg.addr == sece_pkg::A_MACON3)
                                begin
                                    mac3_next = w_val;
                                end
                                else
                                begin
                                    vld_next[ridx] = 1'b1;
                                end

                                // Transmit request
                                if (it_reg.addr == sece_pkg::A_ECON1 &&
                                    (com_next[sece_pkg::C_ECON1] & sece_pkg::TX_REQ_BIT) != 8'h00)
                                begin
                                    st = pair(bk0_next[sece_pkg::P_ETXST],
                                              bk0_next[sece_pkg::P_ETXST + 1]);
                                    nd = pair(bk0_next[sece_pkg::P_ETXND],
                                              bk0_next[sece_pkg::P_ETXND + 1]);
                                    st1_16 = 16'(PW'(st + 1'b1));
                                    nd_16  = 16'(nd);
                                    out_res.go         = 1'b1;
                                    out_res.first_addr = st1_16[12:0];
                                    out_res.last_addr  = nd_16[12:0];
                                    out_res.empty      = (nd < st);
                                    out_res.pad        = (mac3_next & sece_pkg::MACON3_PAD) != 8'h00;
                                    com_next[sece_pkg::C_ECON1] =
                                        com_next[sece_pkg::C_ECON1] & ~sece_pkg::TX_REQ_BIT;
                                    com_next[sece_pkg::C_EIR] =
                                        com_next[sece_pkg::C_EIR] | sece_pkg::TX_DONE_FLAG;
                                end

                                // Packet count decrement
                                if (it_reg.addr == sece_pkg::A_ECON2 &&
                                    (com_next[sece_pkg::C_ECON2] & sece_pkg::ECON2_PKDEC) != 8'h00)
                                begin
                                    if (epkt_next != 8'h00)
                                    begin
                                        epkt_next = epkt_next - 8'd1;
                                    end
                                    if (epkt_next == 8'h00)
                                    begin
                                        com_next[sece_pkg::C_EIR] =
                                            com_next[sece_pkg::C_EIR] & ~sece_pkg::PKT_PEND_FLAG;
                                    end
                                    com_next[sece_pkg::C_ECON2] =
                                        com_next[sece_pkg::C_ECON2] & ~sece_pkg::ECON2_PKDEC;
                                end

                                // Receive start moves the receive write pointer
                                if (bank_reg == 2'd0 && (it_reg.addr == sece_pkg::A_ERXSTL ||
                                                         it_reg.addr == sece_pkg::A_ERXSTH))
                                begin
                                    rx_16 = 16'(pair(bk0_next[sece_pkg::P_ERXST],
                                                     bk0_next[sece_pkg::P_ERXST + 1]));
                                    bk0_next[sece_pkg::P_ERWRPT]     = rx_16[7:0];
                                    bk0_next[sece_pkg::P_ERWRPT + 1] = rx_16[15:8];
                                end
                            end
                            sece_pkg::K_RCR:
                            begin
                                if (dmy_reg)
                                begin
                                    held_next = r_val;
                                    dmy_next  = 1'b0;
                                end
                            end
                            sece_pkg::K_RBM:
                            begin
                                rd_16 = 16'(rdp_reg);
                                bk0_next[sece_pkg::P_ERDPT]     = rd_16[7:0];
                                bk0_next[sece_pkg::P_ERDPT + 1] = rd_16[15:8];
                                held_next = pkt_q;
                            end
                            sece_pkg::K_WBM:
                            begin
                                wr_16 = 16'(PW'(cur_wr + 1'b1));
                                bk0_next[sece_pkg::P_EWRPT]     = wr_16[7:0];
                                bk0_next[sece_pkg::P_EWRPT + 1] = wr_16[15:8];
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                    out_res.miso = held_next;
                end
            end
            default:
            begin
                state_next = sece_pkg::S_FETCH;
            end
        endcase
    end

    assign out_push = commit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sece_pkg::S_CLEAR;
            clr_reg   <= '0;
            for (int i = 0; i < 16; i++)
            begin
                bk0_reg[i] <= 8'h00;
            end
            for (int i = 0; i < 5; i++)
            begin
                com_reg[i] <= 8'h00;
            end
            com_reg[sece_pkg::C_ECON2] <= sece_pkg::ECON2_RST;
            com_reg[sece_pkg::C_ESTAT] <= sece_pkg::ESTAT_RST;
            erxf_reg <= sece_pkg::ERXFCON_RST;
            epkt_reg <= 8'h00;
            mac3_reg <= 8'h00;
            vld_reg  <= '0;
            dmy_reg  <= 1'b0;
            held_reg <= 8'h00;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            bk0_reg   <= bk0_next;
            com_reg   <= com_next;
            erxf_reg  <= erxf_next;
            epkt_reg  <= epkt_next;
            mac3_reg  <= mac3_next;
            vld_reg   <= vld_next;
            dmy_reg   <= dmy_next;
            held_reg  <= held_next;
        end
    end

    // Latch the beat and the bank it runs in
    always_ff @(posedge clk)
    begin
        if (fetch)
        begin
            it_reg   <= q_item;
            bank_reg <= com_reg[sece_pkg::C_ECON1][1:0];
            rdp_reg  <= rdp_calc;
        end
    end

endmodule

>>> hdl/spi_ethernet_command_engine_core.sv
// ----------------------------------------------------------------------------
// spi_ethernet_command_engine_core
// SPI command engine of a small Ethernet controller.
// ----------------------------------------------------------------------------
// Input queue: push a completed SPI byte (mosi_byte, first_byte set on the
// command byte after chip select falls) while full is low.
// Result queue: while empty is low the ports carry the next byte to shift out
// (miso_byte) and, for a register write that set the transmit request bit,
// tx_go with the frame address range and padding flag; pop takes the beat.
// Each input beat yields exactly one result beat, in order.
// The front stage classifies bytes and tracks the active command; a two-entry
// queue feeds the back stage, which reads the register RAM and buffer RAM in
// its fetch state, then executes and writes back in its execute state, and
// fetches the next byte only once the last is committed. A byte passes the
// middle queue, the fetch and execute states and the output queue until
// empty falls. After rst_n the whole buffer memory is cleared, one byte a
// cycle; full stays high during that pass. When the receiver stalls, results
// wait in a two-entry output queue, the back stage holds, and full rises once
// the middle queue fills. BUFFER_BYTES is a power of two.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module spi_ethernet_command_engine_core #(
    parameter int BUFFER_BYTES = 8192
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  mosi_byte,
    input  logic        first_byte,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  miso_byte,
    output logic        tx_go,
    output logic [12:0] tx_first_addr,
    output logic [12:0] tx_last_addr,
    output logic        tx_empty,
    output logic        tx_pad
);

    localparam int IW = $bits(sece_pkg::item_t);
    localparam int RW = $bits(sece_pkg::result_t);

    logic              busy;
    logic              mid_push, mid_full, mid_pop, mid_empty;
    sece_pkg::item_t   mid_din, mid_dout;
    logic              out_push, out_full;
    sece_pkg::result_t out_din, out_dout;

    sece_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .mosi_byte  (mosi_byte),
        .first_byte (first_byte),
        .busy       (busy),
        .q_full     (mid_full),
        .q_push     (mid_push),
        .q_item     (mid_din)
    );

    sece_fifo #(
        .WIDTH (IW),
        .DEPTH (2)
    ) u_mid_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (mid_push),
        .din   (mid_din),
        .full  (mid_full),
        .pop   (mid_pop),
        .dout  (mid_dout),
        .empty (mid_empty)
    );

    sece_back #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (mid_empty),
        .q_item   (mid_dout),
        .q_pop    (mid_pop),
        .out_full (out_full),
        .out_push (out_push),
        .out_res  (out_din),
        .busy     (busy)
    );

    sece_fifo #(
        .WIDTH (RW),
        .DEPTH (2)
    ) u_out_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (out_push),
        .din   (out_din),
        .full  (out_full),
        .pop   (pop),
        .dout  (out_dout),
        .empty (empty)
    );

    assign miso_byte     = out_dout.miso;
    assign tx_go         = out_dout.go;
    assign tx_first_addr = out_dout.first_addr;
    assign tx_last_addr  = out_dout.last_addr;
    assign tx_empty      = out_dout.empty;
    assign tx_pad        = out_dout.pad;

    `SECE_ASSERT_NOW(a_clear_blocks_input, busy, full)
    `SECE_ASSERT_NOW(a_no_tx_fields_idle, (!empty && !tx_go),
        (tx_first_addr == 13'd0 && tx_last_addr == 13'd0 && !tx_empty && !tx_pad))
    `SECE_ASSERT_NOW(a_no_result_overflow, out_push, !out_full)
    `SECE_ASSERT_NEXT(a_pop_after_fetch, (mid_pop && !busy), (!mid_pop))

endmodule

>>> verif/spi_ethernet_command_engine_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SPI Ethernet command engine core test
// Drives command and data bytes through the input queue, tracks the register
// file, banking and buffer memory in a local copy, and checks every shifted
// out byte and transmit request against that copy, under random idling.
// ----------------------------------------------------------------------------
module spi_ethernet_command_engine_core_test;

    localparam int BUF_BYTES = 8192;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int NREG = 27;
    // Opcode fields with no defined command
    localparam logic [2:0] OP_UNK_A = 3'b001;
    localparam logic [2:0] OP_UNK_B = 3'b011;
    localparam logic [2:0] OP_UNK_C = 3'b110;
    localparam logic [2:0] OP_UNK_D = 3'b111;

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    logic [7:0]  mosi_byte;
    logic        first_byte;
    logic        empty;
    logic        pop;
    logic [7:0]  miso_byte;
    logic        tx_go;
    logic [12:0] tx_first_addr;
    logic [12:0] tx_last_addr;
    logic        tx_empty;
    logic        tx_pad;

    // Local copy of the engine state
    logic [7:0]  bank_regs [0:4*NREG-1];
    logic [7:0]  common_regs [0:4];
    logic [7:0]  buf_mem [0:BUF_BYTES-1];
    logic [7:0]  cur_cmd;
    logic [4:0]  cur_reg;
    logic        dummy_wait;
    logic [12:0] rx_wr_ptr;
    logic [7:0]  held_miso;

    sece_pkg::result_t pending_results [$];
    int          send_idle_pct;
    int          recv_idle_pct;
    int          mismatches;
    int          cycles;

    spi_ethernet_command_engine_core u_dut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full),
        .mosi_byte(mosi_byte), .first_byte(first_byte),
        .empty(empty), .pop(pop), .miso_byte(miso_byte), .tx_go(tx_go),
        .tx_first_addr(tx_first_addr), .tx_last_addr(tx_last_addr),
        .tx_empty(tx_empty), .tx_pad(tx_pad)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [12:0] ptr_get(int lo);
        return 13'({bank_regs[lo+1], bank_regs[lo]} % BUF_BYTES);
    endfunction

    function automatic void ptr_set(int lo, logic [12:0] v);
        bank_regs[lo]   = v[7:0];
        bank_regs[lo+1] = {3'b000, v[12:8]};
    endfunction

    function automatic void regs_clear();
        foreach (bank_regs[i]) bank_regs[i] = 8'h00;
        foreach (common_regs[i]) common_regs[i] = 8'h00;
        common_regs[sece_pkg::C_ECON2] = sece_pkg::ECON2_RST;
        common_regs[sece_pkg::C_ESTAT] = sece_pkg::ESTAT_RST;
        bank_regs[NREG + sece_pkg::A_ERXFCON] = sece_pkg::ERXFCON_RST;
        rx_wr_ptr = '0;
    endfunction

    function automatic logic [7:0] reg_rd(int bank, logic [4:0] a);
        if (a >= sece_pkg::BANK_SIZE)
            return common_regs[a - sece_pkg::BANK_SIZE];
        return bank_regs[bank*NREG + a];
    endfunction

    function automatic void reg_wr(int bank, logic [4:0] a, logic [7:0] v);
        if (a >= sece_pkg::BANK_SIZE)
            common_regs[a - sece_pkg::BANK_SIZE] = v;
        else
            bank_regs[bank*NREG + a] = v;
    endfunction

    // Side effects of a register write: transmit request, packet decrement,
    // receive pointer move
    function automatic void write_effects(int bank, logic [4:0] a,
                                          inout sece_pkg::result_t r);
        logic [12:0] st;
        logic [12:0] nd;
        int          cnt_idx;
        cnt_idx = NREG + sece_pkg::A_EPKTCNT;
        if (a == sece_pkg::A_ECON1 &&
            (common_regs[sece_pkg::C_ECON1] & sece_pkg::TX_REQ_BIT) != 0)
        begin
            st = ptr_get(sece_pkg::P_ETXST);
            nd = ptr_get(sece_pkg::P_ETXND);
            r.go = 1'b1;
            r.first_addr = 13'((st + 1) % BUF_BYTES);
            r.last_addr = nd;
            r.empty = nd < st;
            r.pad = (bank_regs[2*NREG + sece_pkg::A_MACON3] & sece_pkg::MACON3_PAD) != 0;
            common_regs[sece_pkg::C_ECON1] &= ~sece_pkg::TX_REQ_BIT;
            common_regs[sece_pkg::C_EIR] |= sece_pkg::TX_DONE_FLAG;
        end
        if (a == sece_pkg::A_ECON2 &&
            (common_regs[sece_pkg::C_ECON2] & sece_pkg::ECON2_PKDEC) != 0)
        begin
            if (bank_regs[cnt_idx] != 0)
                bank_regs[cnt_idx] -= 1;
            if (bank_regs[cnt_idx] == 0)
                common_regs[sece_pkg::C_EIR] &= ~sece_pkg::PKT_PEND_FLAG;
            common_regs[sece_pkg::C_ECON2] &= ~sece_pkg::ECON2_PKDEC;
        end
        if (bank == 0 && (a == sece_pkg::A_ERXSTL || a == sece_pkg::A_ERXSTH))
        begin
            rx_wr_ptr = ptr_get(sece_pkg::P_ERXST);
            ptr_set(sece_pkg::P_ERWRPT, rx_wr_ptr);
        end
    endfunction

    function automatic sece_pkg::result_t predict_byte(logic [7:0] b, logic first);
        sece_pkg::result_t r;
        int          bank;
        logic [12:0] p;
        logic [7:0]  v;
        r = '0;
        bank = int'(common_regs[sece_pkg::C_ECON1][1:0]);
        if (first)
        begin
            dummy_wait = 1'b0;
            if (b == sece_pkg::CMD_SRC)
            begin
                cur_cmd = sece_pkg::CMD_SRC;
                regs_clear();
                held_miso = 8'h00;
            end
            else if (b == sece_pkg::CMD_RBM)
            begin
                cur_cmd = sece_pkg::CMD_RBM;
                held_miso = buf_mem[ptr_get(sece_pkg::P_ERDPT)];
            end
            else if (b == sece_pkg::CMD_WBM)
            begin
                cur_cmd = sece_pkg::CMD_WBM;
                held_miso = 8'h00;
            end
            else
            begin
                cur_cmd = b & 8'hE0;
                cur_reg = b[4:0];
                if (cur_cmd[7:5] == sece_pkg::OP_RCR)
                begin
                    dummy_wait = bank == 2 || (bank == 3 &&
                        (cur_reg <= sece_pkg::A_DMY_LAST || cur_reg == sece_pkg::A_DMY_ALT));
                    held_miso = dummy_wait ? 8'h00 : reg_rd(bank, cur_reg);
                end
                else
                    held_miso = 8'h00;
            end
        end
        else if (cur_cmd == sece_pkg::CMD_RBM)
        begin
            p = ptr_get(sece_pkg::P_ERDPT);
            if (p == ptr_get(sece_pkg::P_ERXND))
                p = ptr_get(sece_pkg::P_ERXST);
            else
                p = 13'((p + 1) % BUF_BYTES);
            ptr_set(sece_pkg::P_ERDPT, p);
            held_miso = buf_mem[p];
        end
        else if (cur_cmd == sece_pkg::CMD_WBM)
        begin
            p = ptr_get(sece_pkg::P_EWRPT);
            buf_mem[p] = b;
            ptr_set(sece_pkg::P_EWRPT, 13'((p + 1) % BUF_BYTES));
        end
        else if (cur_cmd != sece_pkg::CMD_SRC)
        begin
            v = reg_rd(bank, cur_reg);
            case (cur_cmd[7:5])
                sece_pkg::OP_WCR:
                begin
                    reg_wr(bank, cur_reg, b);
                    write_effects(bank, cur_reg, r);
                end
                sece_pkg::OP_BFS:
                begin
                    reg_wr(bank, cur_reg, v | b);
                    write_effects(bank, cur_reg, r);
                end
                sece_pkg::OP_BFC:
                begin
                    reg_wr(bank, cur_reg, v & ~b);
                    write_effects(bank, cur_reg, r);
                end
                sece_pkg::OP_RCR:
                begin
                    if (dummy_wait)
                    begin
                        held_miso = v;
                        dummy_wait = 1'b0;
                    end
                end
                default: ;
            endcase
        end
        r.miso = held_miso;
        return r;
    endfunction

    // Send one beat; push stays high on return so back-to-back beats do not gap
    task automatic send_byte(logic [7:0] b, logic first);
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        mosi_byte <= b;
        first_byte <= first;
        @(posedge clk);
        while (full)
            @(posedge clk);
        pending_results.push_back(predict_byte(b, first));
    endtask

    task automatic send_cmd(logic [2:0] op, logic [4:0] a);
        send_byte({op, a}, 1'b1);
    endtask

    task automatic write_reg(logic [4:0] a, logic [7:0] v);
        send_cmd(sece_pkg::OP_WCR, a);
        send_byte(v, 1'b0);
    endtask

    always @(posedge clk)
    begin
        sece_pkg::result_t want;
        if (rst_n && pop && !empty)
        begin
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: miso %h", miso_byte);
            end
            else
            begin
                want = pending_results.pop_front();
                if (miso_byte !== want.miso || tx_go !== want.go ||
                    tx_first_addr !== want.first_addr ||
                    tx_last_addr !== want.last_addr ||
                    tx_empty !== want.empty || tx_pad !== want.pad)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: exp miso %h go %b first %h last %h ",
                                  "empty %b pad %b, got miso %h go %b first %h ",
                                  "last %h empty %b pad %b"},
                            want.miso, want.go, want.first_addr, want.last_addr,
                            want.empty, want.pad, miso_byte, tx_go, tx_first_addr,
                            tx_last_addr, tx_empty, tx_pad);
                end
            end
        end
        pop <= $urandom_range(99) >= recv_idle_pct;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic test_directed();
        send_byte(8'h55, 1'b0);                     // data with no command yet
        send_cmd(sece_pkg::OP_RCR, sece_pkg::A_ERXFCON);  // bank 0 read
        send_byte(8'h00, 1'b0);
        write_reg(sece_pkg::A_ECON1, 8'h02);        // bank 2: dummy byte reads
        send_cmd(sece_pkg::OP_RCR, sece_pkg::A_MACON3);
        send_byte(8'h00, 1'b0);
        send_cmd(sece_pkg::OP_BFS, sece_pkg::A_MACON3);
        send_byte(8'hE0, 1'b0);
        write_reg(sece_pkg::A_ECON1, 8'h00);
        write_reg(5'h04, 8'hFF);                    // ETXST above ETXND
        write_reg(5'h05, 8'hFF);
        send_cmd(sece_pkg::OP_BFS, sece_pkg::A_ECON1);    // raise transmit
        send_byte(8'h08, 1'b0);
        send_cmd(sece_pkg::OP_BFC, sece_pkg::A_ECON1);
        send_byte(8'hFF, 1'b0);
        send_byte(sece_pkg::CMD_WBM, 1'b1);
        send_byte(8'hA5, 1'b0);
        send_byte(sece_pkg::CMD_RBM, 1'b1);
        send_byte(8'h00, 1'b0);                     // read pointer equals ERXND: wrap
        send_cmd(OP_UNK_D, 5'h1F);
        send_byte(8'h12, 1'b0);
        send_byte(sece_pkg::CMD_SRC, 1'b1);
        send_byte(8'h34, 1'b0);                     // ignored after soft reset
    endtask

    task automatic random_seq();
        int          kind;
        int          n;
        logic [4:0]  a;
        logic [2:0]  unk [4];
        unk = '{OP_UNK_A, OP_UNK_B, OP_UNK_C, OP_UNK_D};
        kind = $urandom_range(15);
        a = 5'($urandom_range(31));
        if ($urandom_range(3) == 0)
            a = 5'(27 + $urandom_range(4));
        else if ($urandom_range(2) == 0)
            a = 5'($urandom_range(11));
        n = $urandom_range(1, 4);
        case (kind)
            0, 1:
            begin
                send_cmd(sece_pkg::OP_RCR, a);
                repeat ($urandom_range(1, 2)) send_byte(8'($urandom_range(255)), 1'b0);
            end
            2, 3, 4:
            begin
                write_reg(a, 8'($urandom_range(255)));
            end
            5:
            begin
                send_cmd(sece_pkg::OP_BFS, a);
                send_byte(8'($urandom_range(255)), 1'b0);
            end
            6:
            begin
                send_cmd(sece_pkg::OP_BFC, a);
                send_byte(8'($urandom_range(255)), 1'b0);
            end
            7:
            begin
                write_reg(sece_pkg::A_ECON1, {4'h0, 1'b1, 1'b0, 2'($urandom_range(3))});
            end
            8:
            begin
                write_reg(sece_pkg::A_ECON2, 8'($urandom_range(255)));
            end
            9:
            begin
                send_byte(sece_pkg::CMD_RBM, 1'b1);
                repeat (n) send_byte(8'($urandom_range(255)), 1'b0);
            end
            10:
            begin
                send_byte(sece_pkg::CMD_WBM, 1'b1);
                repeat (n) send_byte(8'($urandom_range(255)), 1'b0);
            end
            11:
            begin
                write_reg(sece_pkg::A_ECON1, 8'($urandom_range(3)));
            end
            12:
            begin
                send_cmd(unk[$urandom_range(3)], a);
                send_byte(8'($urandom_range(255)), 1'b0);
            end
            13:
            begin
                if ($urandom_range(7) == 0)
                    send_byte(sece_pkg::CMD_SRC, 1'b1);
                send_byte(8'($urandom_range(255)), 1'b0);
            end
            default:
            begin
                send_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
            end
        endcase
    endtask

    task automatic test_random(int sends, int r_idle, int items);
        send_idle_pct = sends;
        recv_idle_pct = r_idle;
        repeat (items / 2) random_seq();
    endtask

    initial
    begin
        rst_n = 1'b0;
        push = 1'b0;
        pop = 1'b0;
        mosi_byte = 8'h00;
        first_byte = 1'b0;
        mismatches = 0;
        cycles = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        regs_clear();
        foreach (buf_mem[i]) buf_mem[i] = 8'h00;
        cur_cmd = 8'h00;
        cur_reg = 5'h00;
        dummy_wait = 1'b0;
        held_miso = 8'h00;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(16, 59, 230);
        test_random(59, 16, 230);
        test_random(0, 0, 230);
        push <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
